/* rtl/lkv_pkg.sv */
package lkv_pkg;

    // store geometry
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int AGE_W       = IDX_W;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // field widths
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;
    localparam int OCC_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // operation codes
    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    // input item as it arrives on the port
    typedef struct packed {
        logic                     mode;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    // classified item held in the queue
    typedef struct packed {
        t_op                      op;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    // result item
    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
        logic signed [DATA_W-1:0] evicted_key;
        logic [OCC_W-1:0]         occupancy;
    } t_out_item;

endpackage

/* rtl/lkv_ram.sv */
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/lkv_front.sv */
module lkv_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  lkv_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    output lkv_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_pop
);

    localparam int QDEPTH = 2;

    lkv_pkg::t_cmd r_q [QDEPTH];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    lkv_pkg::t_cmd cmd_in;
    logic          push;
    logic          pop;

    // classify the incoming item
    always_comb begin
        cmd_in.op    = lkv_pkg::t_op'(i_item.mode);
        cmd_in.key   = i_item.key;
        cmd_in.value = i_item.value;
    end

    assign o_stall     = (r_cnt == 2'(QDEPTH));
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    // two-entry queue toward the back end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= cmd_in;
                r_wp      <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* rtl/lkv_back.sv */
module lkv_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [lkv_pkg::CAP_W-1:0]  i_capacity,
    input  logic                       i_cmd_valid,
    input  lkv_pkg::t_cmd              i_cmd,
    output logic                       o_cmd_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output lkv_pkg::t_out_item         o_out_item
);

    localparam int N     = lkv_pkg::MAX_ENTRIES;
    localparam int IW    = lkv_pkg::IDX_W;
    localparam int AW    = lkv_pkg::AGE_W;
    localparam int CW    = lkv_pkg::CNT_W;
    localparam int DW    = lkv_pkg::DATA_W;
    localparam int CMP_W = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;

    typedef enum logic {
        S_LOOK,
        S_EXEC
    } t_state;

    t_state             r_state;
    logic [DW-1:0]      r_key [N];
    logic [N-1:0]       r_valid;
    logic [AW-1:0]      r_age [N];
    logic [CW-1:0]      r_live;
    lkv_pkg::t_cmd      r_cmd;
    logic               r_hit;
    logic [IW-1:0]      r_hit_idx;
    logic [IW-1:0]      r_free_idx;
    logic [IW-1:0]      r_old_idx;
    logic               r_out_valid;
    lkv_pkg::t_out_item r_out;

    logic [N-1:0]       match;
    logic [IW-1:0]      hit_idx;
    logic [IW-1:0]      free_idx;
    logic [IW-1:0]      old_idx;
    logic [CW-1:0]      live_m1;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   eff_cap;
    logic               has_room;
    logic               go_exec;
    logic               is_add;
    logic               do_evict;
    logic               do_grow;
    logic [IW-1:0]      slot;
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [IW-1:0]      ram_raddr;
    logic [DW-1:0]      ram_rdata;

    // associative compare, free slot and oldest entry search
    assign live_m1 = r_live - CW'(1);
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        old_idx  = '0;
        for (int i = N - 1; i >= 0; i--) begin
            match[i] = r_valid[i] && (r_key[i] == i_cmd.key);
            if (match[i]) begin
                hit_idx = IW'(i);
            end
            if (!r_valid[i]) begin
                free_idx = IW'(i);
            end
            if (r_valid[i] && (CW'(r_age[i]) == live_m1)) begin
                old_idx = IW'(i);
            end
        end
    end

    // effective capacity: zero reads as one, saturate at the store size
    always_comb begin
        cap_ext = CMP_W'(i_capacity);
        if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(N)) begin
            eff_cap = CMP_W'(N);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign has_room  = CMP_W'(r_live) < eff_cap;
    assign go_exec   = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign is_add    = (r_cmd.op == lkv_pkg::OP_ADD);
    assign do_evict  = is_add && !r_hit && !has_room;
    assign do_grow   = is_add && !r_hit && has_room;
    assign slot      = r_hit ? r_hit_idx : (has_room ? r_free_idx : r_old_idx);
    assign ram_we    = go_exec && is_add;
    assign ram_waddr = slot;
    // keep the hit entry addressed while the item waits in execute
    assign ram_raddr = (r_state == S_LOOK) ? hit_idx : r_hit_idx;
    assign o_cmd_pop = (r_state == S_LOOK) && i_cmd_valid;

    // value store
    lkv_ram #(
        .WIDTH (DW),
        .DEPTH (N)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_cmd.value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer, entry state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOOK;
            r_valid     <= '0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < N; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            if (go_exec) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOOK: begin
                    if (i_cmd_valid) begin
                        r_cmd      <= i_cmd;
                        r_hit      <= |match;
                        r_hit_idx  <= hit_idx;
                        r_free_idx <= free_idx;
                        r_old_idx  <= old_idx;
                        r_state    <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (go_exec) begin
                        r_out.hit            <= r_hit;
                        r_out.read_value     <= (!is_add && r_hit) ? ram_rdata : '0;
                        r_out.evicted        <= do_evict;
                        r_out.evicted_key    <= do_evict ? r_key[r_old_idx] : '0;
                        r_out.occupancy      <= lkv_pkg::OCC_W'(do_grow ? r_live + CW'(1)
                                                                        : r_live);
                        if (is_add) begin
                            // new entry is newest; entries newer than the refreshed one,
                            // or all on a miss, age by one
                            for (int i = 0; i < N; i++) begin
                                if (IW'(i) == slot) begin
                                    r_age[i] <= '0;
                                end else if (r_valid[i] &&
                                             (!r_hit || (r_age[i] < r_age[r_hit_idx]))) begin
                                    r_age[i] <= r_age[i] + AW'(1);
                                end
                            end
                            r_valid[slot] <= 1'b1;
                            r_key[slot]   <= r_cmd.key;
                            if (do_grow) begin
                                r_live <= r_live + CW'(1);
                            end
                        end
                        r_state <= S_LOOK;
                    end
                end
                default: r_state <= S_LOOK;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

/* rtl/lru_key_value_cache.sv */
// Fully associative key-value cache with least-recently-used replacement,
// up to 16 entries, live count capped by the capacity register (0 acts as 1,
// values above 16 act as 16). Each item gives one result. An item passes through
// the engine's lookup state, for the compare of its key against every stored
// key plus the read of the value memory, and then its execute state, for the
// recency update and the write-back; the engine takes no new item until execute
// is done. A two-item queue sits at the input and the result waits in an output
// register. Capacity must be written only while the cache is idle; the block
// itself does not enforce this.
module lru_key_value_cache (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  lkv_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output lkv_pkg::t_out_item         o_out_item,
    input  logic                       i_cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]  i_cfg_data
);

    logic [lkv_pkg::CAP_W-1:0] r_capacity;
    logic                      cmd_valid;
    lkv_pkg::t_cmd             cmd;
    logic                      cmd_pop;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lkv_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_data;
        end
    end

    // intake and queue
    lkv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_item      (i_in_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // lookup and update engine
    lkv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_capacity  (r_capacity),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // occupancy never passes the store size
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.occupancy <= lkv_pkg::OCC_W'(lkv_pkg::MAX_ENTRIES)))
        else $error("occupancy above store size");

    // an eviction only comes from a missed add
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.evicted) |-> !o_out_item.hit)
        else $error("eviction on a hit");

    // a returned value implies a hit without eviction
    a_value_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.read_value != '0)) |->
        (o_out_item.hit && !o_out_item.evicted))
        else $error("value returned without hit");

    // an evicted key is reported only with the eviction flag
    a_evkey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.evicted) |-> (o_out_item.evicted_key == '0))
        else $error("evicted key without eviction");

endmodule
